FILE: design/fbik_pkg.sv
package fbik_pkg;

  // Internal datapath widths, fixed by the pre-shift normalization of p, q, r
  localparam int MUL_W  = 30;  // multiplier operand
  localparam int PROD_W = 60;  // product and accumulator
  localparam int RAD_W  = 58;  // square root radicand
  localparam int ROOT_W = 29;  // square root result
  localparam int REM_W  = 32;  // square root remainder
  localparam int ND_W   = 31;  // atan numerator and denominator
  localparam int CX_W   = 44;  // rotation vector
  localparam int Z_W    = 32;  // accumulated angle, pi/2^30
  localparam int ANG_W  = 34;  // rounded output angle before the range check
  localparam int LINK_W = 13;
  localparam int LIM_W  = 14;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 14;
  localparam int CORDIC_STEPS = 28;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_MAX   = 3'd6;

  localparam int NUM_LANES = 4;

  typedef enum logic [2:0] {
    LS_IDLE,
    LS_MUL,
    LS_SQRT,
    LS_PREP,
    LS_NORM,
    LS_ROT,
    LS_FIN
  } lane_state_e;

  typedef struct packed {
    logic done;
    logic held;
  } lane_stat_t;

  // Arctangent of 2^-i in units of pi/2^30
  function automatic logic signed [Z_W-1:0] atan_tab(input logic [4:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:  v = 32'sd268435456;
      5'd1:  v = 32'sd158466703;
      5'd2:  v = 32'sd83729454;
      5'd3:  v = 32'sd42502378;
      5'd4:  v = 32'sd21333665;
      5'd5:  v = 32'sd10677233;
      5'd6:  v = 32'sd5339919;
      5'd7:  v = 32'sd2670122;
      5'd8:  v = 32'sd1335082;
      5'd9:  v = 32'sd667543;
      5'd10: v = 32'sd333772;
      5'd11: v = 32'sd166886;
      5'd12: v = 32'sd83443;
      5'd13: v = 32'sd41722;
      5'd14: v = 32'sd20861;
      5'd15: v = 32'sd10430;
      5'd16: v = 32'sd5215;
      5'd17: v = 32'sd2608;
      5'd18: v = 32'sd1304;
      5'd19: v = 32'sd652;
      5'd20: v = 32'sd326;
      5'd21: v = 32'sd163;
      5'd22: v = 32'sd81;
      5'd23: v = 32'sd41;
      5'd24: v = 32'sd20;
      5'd25: v = 32'sd10;
      5'd26: v = 32'sd5;
      5'd27: v = 32'sd3;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: design/fbik_lane.sv
module fbik_lane #(
  parameter int COORD_BITS = 14,
  parameter int ANGLE_BITS = 16,
  parameter bit IS_ALPHA = 1'b1
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           start_i,
  input  logic signed [((COORD_BITS > 14) ? COORD_BITS : 14):0] x_i,
  input  logic signed [((COORD_BITS > 14) ? COORD_BITS : 14):0] y_i,
  input  logic [fbik_pkg::LINK_W-1:0]                    la_i,
  input  logic [fbik_pkg::LINK_W-1:0]                    lb_i,
  output logic [ANGLE_BITS-1:0]                          angle_o,
  output fbik_pkg::lane_stat_t                           stat_o
);

  localparam int MAG = (COORD_BITS > 14) ? COORD_BITS : 14;
  localparam int CW  = MAG + 1;
  localparam int PS  = 2 * MAG - 28;
  localparam int OS  = 31 - ANGLE_BITS;
  localparam int MW  = fbik_pkg::MUL_W;
  localparam int PW  = fbik_pkg::PROD_W;
  localparam int NW  = fbik_pkg::ND_W;
  localparam int XW  = fbik_pkg::CX_W;
  localparam int ZW  = fbik_pkg::Z_W;
  localparam int AW  = fbik_pkg::ANG_W;
  localparam logic signed [AW-1:0] RND    = 34'sd1 <<< (OS - 1);
  localparam logic signed [AW-1:0] TWO_PI = 34'sd1 <<< ANGLE_BITS;
  localparam logic signed [AW-1:0] LIM    =
      IS_ALPHA ? (34'sd1 <<< (ANGLE_BITS - 1)) : (34'sd1 <<< (ANGLE_BITS - 2));
  localparam logic signed [ZW-1:0] HALF_PI = 32'sd1 <<< 29;

  fbik_pkg::lane_state_e state_q, state_d;

  logic [3:0]                          step_q;
  logic signed [CW-1:0]                x_q, y_q;
  logic [fbik_pkg::LINK_W-1:0]         la_q, lb_q;
  logic signed [PW-1:0]                prod_q, acc_q;
  logic signed [MW-1:0]                p_q, q_q, r_q;
  logic [fbik_pkg::RAD_W-1:0]          rad_q;
  logic [fbik_pkg::REM_W-1:0]          rem_q;
  logic [fbik_pkg::ROOT_W-1:0]         root_q;
  logic [4:0]                          cnt_q;
  logic                                k_q;
  logic signed [XW-1:0]                cx_q, cy_q;
  logic signed [ZW-1:0]                cz_q;
  logic                                neg_q;
  logic [ANGLE_BITS-1:0]               last_q;
  logic                                held_q, done_q;

  // Datapath terms
  logic signed [MW-1:0] op_a, op_b;
  logic signed [PW-1:0] prod_d, twice_sh, acc_sh, disc;
  logic [fbik_pkg::REM_W-1:0] rem_sh, trial;
  logic signed [NW-1:0] num, den;
  logic signed [XW-1:0] num_e, den_e, shx, shy;
  logic signed [ZW-1:0] zf;
  logic signed [AW-1:0] a2, ang, ang_w;
  logic                 fits;
  logic [XW-1:0]        mag_or;

  // Pick multiplier operands for each step
  always_comb begin
    case (step_q)
      4'd0:    begin op_a = MW'(x_q); op_b = MW'(x_q); end
      4'd1:    begin op_a = MW'(y_q); op_b = MW'(y_q); end
      4'd2:    begin
        op_a = $signed({{(MW-fbik_pkg::LINK_W){1'b0}}, la_q});
        op_b = op_a;
      end
      4'd3:    begin
        op_a = $signed({{(MW-fbik_pkg::LINK_W){1'b0}}, lb_q});
        op_b = op_a;
      end
      4'd4:    begin
        op_a = MW'(x_q);
        op_b = $signed({{(MW-fbik_pkg::LINK_W){1'b0}}, la_q});
      end
      4'd5:    begin
        op_a = MW'(y_q);
        op_b = $signed({{(MW-fbik_pkg::LINK_W){1'b0}}, la_q});
      end
      4'd6:    begin op_a = p_q; op_b = p_q; end
      4'd7:    begin op_a = q_q; op_b = q_q; end
      4'd8:    begin op_a = r_q; op_b = r_q; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign prod_d   = op_a * op_b;
  assign twice_sh = (prod_q <<< 1) >>> PS;
  assign acc_sh   = acc_q >>> PS;
  assign disc     = acc_q - prod_q;

  // One square root digit per cycle
  assign rem_sh = {rem_q[fbik_pkg::REM_W-3:0], rad_q[fbik_pkg::RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};

  // Root candidate and denominator
  always_comb begin
    den = NW'(p_q) + NW'(r_q);
    if (k_q) begin
      num = NW'(q_q) - $signed({2'b00, root_q});
    end else begin
      num = NW'(q_q) + $signed({2'b00, root_q});
    end
    num_e = XW'(num);
    den_e = XW'(den);
  end

  assign mag_or = cx_q | cy_q;
  assign shx    = cx_q >>> cnt_q;
  assign shy    = cy_q >>> cnt_q;

  // Round twice the angle and check the range
  always_comb begin
    zf    = neg_q ? -cz_q : cz_q;
    a2    = AW'(zf) <<< 1;
    ang   = (a2 + RND) >>> OS;
    ang_w = (IS_ALPHA && ang[AW-1]) ? ang + TWO_PI : ang;
    fits  = !ang_w[AW-1] && (ang_w <= LIM);
  end

  // Sequence the lane
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fbik_pkg::LS_IDLE: if (start_i) state_d = fbik_pkg::LS_MUL;
      fbik_pkg::LS_MUL:  if (step_q == 4'd9) state_d = fbik_pkg::LS_SQRT;
      fbik_pkg::LS_SQRT: if (cnt_q == 5'(fbik_pkg::ROOT_W - 1)) state_d = fbik_pkg::LS_PREP;
      fbik_pkg::LS_PREP: begin
        if (den == '0 || num == '0) state_d = fbik_pkg::LS_FIN;
        else state_d = fbik_pkg::LS_NORM;
      end
      fbik_pkg::LS_NORM: if (mag_or[XW-1:40] != '0) state_d = fbik_pkg::LS_ROT;
      fbik_pkg::LS_ROT:  if (cnt_q == 5'(fbik_pkg::CORDIC_STEPS - 1)) state_d = fbik_pkg::LS_FIN;
      fbik_pkg::LS_FIN: begin
        if (fits || k_q) state_d = fbik_pkg::LS_IDLE;
        else state_d = fbik_pkg::LS_PREP;
      end
      default: state_d = fbik_pkg::LS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fbik_pkg::LS_IDLE;
      last_q  <= '0;
      held_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      if (state_q == fbik_pkg::LS_FIN) begin
        if (fits) begin
          last_q <= ang_w[ANGLE_BITS-1:0];
          held_q <= 1'b0;
          done_q <= 1'b1;
        end else if (k_q) begin
          held_q <= 1'b1;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      fbik_pkg::LS_IDLE: begin
        x_q    <= x_i;
        y_q    <= y_i;
        la_q   <= la_i;
        lb_q   <= lb_i;
        step_q <= '0;
      end
      fbik_pkg::LS_MUL: begin
        prod_q <= prod_d;
        step_q <= step_q + 4'd1;
        case (step_q)
          4'd1, 4'd7: acc_q <= prod_q;
          4'd2, 4'd3, 4'd8: acc_q <= acc_q + prod_q;
          4'd4: acc_q <= acc_q - prod_q;
          4'd5: begin
            p_q <= twice_sh[MW-1:0];
            r_q <= acc_sh[MW-1:0];
          end
          4'd6: q_q <= twice_sh[MW-1:0];
          4'd9: begin
            rad_q  <= (disc > 0) ? disc[fbik_pkg::RAD_W-1:0] : '0;
            rem_q  <= '0;
            root_q <= '0;
            cnt_q  <= '0;
          end
          default: ;
        endcase
      end
      fbik_pkg::LS_SQRT: begin
        rad_q <= rad_q << 2;
        cnt_q <= cnt_q + 5'd1;
        if (rem_sh >= trial) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[fbik_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[fbik_pkg::ROOT_W-2:0], 1'b0};
        end
        k_q <= 1'b0;
      end
      fbik_pkg::LS_PREP: begin
        cnt_q <= '0;
        neg_q <= 1'b0;
        if (den == '0) begin
          cz_q <= (num > 0) ? HALF_PI : ((num < 0) ? -HALF_PI : '0);
        end else if (num == '0) begin
          cz_q <= '0;
        end else begin
          neg_q <= num[NW-1] ^ den[NW-1];
          cx_q  <= den_e[XW-1] ? -den_e : den_e;
          cy_q  <= num_e[XW-1] ? -num_e : num_e;
          cz_q  <= '0;
        end
      end
      fbik_pkg::LS_NORM: begin
        // Scale so the larger magnitude lies in [2^40, 2^41)
        if (mag_or[XW-1:37] == '0) begin
          cx_q <= cx_q <<< 4;
          cy_q <= cy_q <<< 4;
        end else if (mag_or[XW-1:40] == '0) begin
          cx_q <= cx_q <<< 1;
          cy_q <= cy_q <<< 1;
        end
      end
      fbik_pkg::LS_ROT: begin
        cnt_q <= cnt_q + 5'd1;
        if (!cy_q[XW-1] && cy_q != '0) begin
          cx_q <= cx_q + shy;
          cy_q <= cy_q - shx;
          cz_q <= cz_q + fbik_pkg::atan_tab(cnt_q);
        end else begin
          cx_q <= cx_q - shy;
          cy_q <= cy_q + shx;
          cz_q <= cz_q - fbik_pkg::atan_tab(cnt_q);
        end
      end
      fbik_pkg::LS_FIN: if (!fits) k_q <= 1'b1;
      default: ;
    endcase
  end

  assign angle_o     = last_q;
  assign stat_o.done = done_q;
  assign stat_o.held = held_q;

endmodule

FILE: design/fbik_merge.sv
module fbik_merge #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fbik_pkg::lane_stat_t  stat_i [fbik_pkg::NUM_LANES],
  input  logic [ANGLE_BITS-1:0] angle_i [fbik_pkg::NUM_LANES],
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic [ANGLE_BITS-1:0] left_alpha_o,
  output logic [ANGLE_BITS-2:0] left_beta_o,
  output logic [ANGLE_BITS-1:0] right_alpha_o,
  output logic [ANGLE_BITS-2:0] right_beta_o,
  output logic                  left_alpha_held_o,
  output logic                  left_beta_held_o,
  output logic                  right_alpha_held_o,
  output logic                  right_beta_held_o,
  output logic                  free_o
);

  logic [fbik_pkg::NUM_LANES-1:0] seen_q;
  logic                           valid_q;
  logic                           load;

  // Load once every lane has finished and the output slot is open
  assign load   = (&seen_q) && (!valid_q || !out_stall_i);
  assign free_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        seen_q  <= '0;
        valid_q <= 1'b1;
      end else begin
        for (int i = 0; i < fbik_pkg::NUM_LANES; i++) begin
          if (stat_i[i].done) seen_q[i] <= 1'b1;
        end
        if (!out_stall_i) valid_q <= 1'b0;
      end
    end
  end

  // Output item register
  always_ff @(posedge clk_i) begin
    if (load) begin
      left_alpha_o       <= angle_i[0];
      left_beta_o        <= angle_i[1][ANGLE_BITS-2:0];
      right_alpha_o      <= angle_i[2];
      right_beta_o       <= angle_i[3][ANGLE_BITS-2:0];
      left_alpha_held_o  <= stat_i[0].held;
      left_beta_held_o   <= stat_i[1].held;
      right_alpha_held_o <= stat_i[2].held;
      right_beta_held_o  <= stat_i[3].held;
    end
  end

  assign out_valid_o = valid_q;

endmodule

FILE: design/five_bar_leg_inverse_kinematics_core.sv
// Channel   Handshake                  Payload
// input     in_valid_i / in_stall_o    left_x_i, left_y_i, right_x_i, right_y_i
// output    out_valid_o / out_stall_i  four angles, four held flags
// config    cfg_we_i (no wait)         cfg_idx_i, cfg_data_i
//
// Four lanes solve left alpha, left beta, right alpha and right beta side by side.
// An item passes from acceptance to the output register through 10 multiply steps on
// one multiplier per lane and 29 square root digits, then per root candidate a setup
// step, scaling, 28 CORDIC rotations and a range check;
// a candidate with a zero numerator or denominator skips scaling and rotations, and a
// second candidate is tried only when the first is out of range.
// The merge block then collects the lane done flags and loads the output register.
// A new item is taken once the previous one has moved into the output register.
// Reset restores the link and limit registers and clears the held angles.
module five_bar_leg_inverse_kinematics_core #(
  parameter int COORD_BITS = 14,
  parameter int ANGLE_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [COORD_BITS-1:0]       left_x_i,
  input  logic signed [COORD_BITS-1:0]       left_y_i,
  input  logic signed [COORD_BITS-1:0]       right_x_i,
  input  logic signed [COORD_BITS-1:0]       right_y_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [ANGLE_BITS-1:0]              left_alpha_o,
  output logic [ANGLE_BITS-2:0]              left_beta_o,
  output logic [ANGLE_BITS-1:0]              right_alpha_o,
  output logic [ANGLE_BITS-2:0]              right_beta_o,
  output logic                               left_alpha_held_o,
  output logic                               left_beta_held_o,
  output logic                               right_alpha_held_o,
  output logic                               right_beta_held_o,
  input  logic                               cfg_we_i,
  input  logic [fbik_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [fbik_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int MAG = (COORD_BITS > 14) ? COORD_BITS : 14;
  localparam int CW  = MAG + 1;

  logic [fbik_pkg::LINK_W-1:0]       upper_a_q, lower_a_q, lower_b_q, upper_b_q, span_q;
  logic signed [fbik_pkg::LIM_W-1:0] y_min_q, y_max_q;
  logic                              busy_q;
  logic                              accept, free;

  logic signed [CW-1:0] lx, ly, rx, ry, lxr, rxr, ly_c, ry_c, ymin_e, ymax_e, span_e;

  fbik_pkg::lane_stat_t  stat [fbik_pkg::NUM_LANES];
  logic [ANGLE_BITS-1:0] angle [fbik_pkg::NUM_LANES];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_a_q <= 13'd1200;
      lower_a_q <= 13'd2400;
      lower_b_q <= 13'd2400;
      upper_b_q <= 13'd1200;
      span_q    <= 13'd960;
      y_min_q   <= 14'sd1760;
      y_max_q   <= 14'sd4800;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fbik_pkg::CFG_UPPER_A: upper_a_q <= cfg_data_i[fbik_pkg::LINK_W-1:0];
        fbik_pkg::CFG_LOWER_A: lower_a_q <= cfg_data_i[fbik_pkg::LINK_W-1:0];
        fbik_pkg::CFG_LOWER_B: lower_b_q <= cfg_data_i[fbik_pkg::LINK_W-1:0];
        fbik_pkg::CFG_UPPER_B: upper_b_q <= cfg_data_i[fbik_pkg::LINK_W-1:0];
        fbik_pkg::CFG_SPAN:    span_q    <= cfg_data_i[fbik_pkg::LINK_W-1:0];
        fbik_pkg::CFG_Y_MIN:   y_min_q   <= $signed(cfg_data_i);
        fbik_pkg::CFG_Y_MAX:   y_max_q   <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Clamp y, the maximum test first, and shift x to the far base joint
  always_comb begin
    lx     = CW'(left_x_i);
    ly     = CW'(left_y_i);
    rx     = CW'(right_x_i);
    ry     = CW'(right_y_i);
    ymin_e = CW'(y_min_q);
    ymax_e = CW'(y_max_q);
    span_e = $signed({{(CW-fbik_pkg::LINK_W){1'b0}}, span_q});
    ly_c   = (ly > ymax_e) ? ymax_e : ((ly < ymin_e) ? ymin_e : ly);
    ry_c   = (ry > ymax_e) ? ymax_e : ((ry < ymin_e) ? ymin_e : ry);
    lxr    = lx - span_e;
    rxr    = rx - span_e;
  end

  assign accept     = in_valid_i && !busy_q;
  assign in_stall_o = busy_q;

  // Hold busy from accept until the lanes hand over to the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (free) begin
      busy_q <= 1'b0;
    end
  end

  fbik_lane #(.COORD_BITS(COORD_BITS), .ANGLE_BITS(ANGLE_BITS), .IS_ALPHA(1'b1)) u_lane_la (
    .clk_i, .rst_ni, .start_i(accept), .x_i(lx), .y_i(ly_c),
    .la_i(upper_a_q), .lb_i(lower_a_q), .angle_o(angle[0]), .stat_o(stat[0])
  );

  fbik_lane #(.COORD_BITS(COORD_BITS), .ANGLE_BITS(ANGLE_BITS), .IS_ALPHA(1'b0)) u_lane_lb (
    .clk_i, .rst_ni, .start_i(accept), .x_i(lxr), .y_i(ly_c),
    .la_i(upper_b_q), .lb_i(lower_b_q), .angle_o(angle[1]), .stat_o(stat[1])
  );

  fbik_lane #(.COORD_BITS(COORD_BITS), .ANGLE_BITS(ANGLE_BITS), .IS_ALPHA(1'b1)) u_lane_ra (
    .clk_i, .rst_ni, .start_i(accept), .x_i(rx), .y_i(ry_c),
    .la_i(upper_a_q), .lb_i(lower_a_q), .angle_o(angle[2]), .stat_o(stat[2])
  );

  fbik_lane #(.COORD_BITS(COORD_BITS), .ANGLE_BITS(ANGLE_BITS), .IS_ALPHA(1'b0)) u_lane_rb (
    .clk_i, .rst_ni, .start_i(accept), .x_i(rxr), .y_i(ry_c),
    .la_i(upper_b_q), .lb_i(lower_b_q), .angle_o(angle[3]), .stat_o(stat[3])
  );

  fbik_merge #(.ANGLE_BITS(ANGLE_BITS)) u_merge (
    .clk_i,
    .rst_ni,
    .stat_i(stat),
    .angle_i(angle),
    .out_stall_i,
    .out_valid_o,
    .left_alpha_o,
    .left_beta_o,
    .right_alpha_o,
    .right_beta_o,
    .left_alpha_held_o,
    .left_beta_held_o,
    .right_alpha_held_o,
    .right_beta_held_o,
    .free_o(free)
  );

endmodule

FILE: design/fbik_checker.sv
module fbik_checker #(
  parameter int ANGLE_BITS = 16
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [ANGLE_BITS-1:0] left_alpha_o,
  input logic [ANGLE_BITS-2:0] left_beta_o,
  input logic [ANGLE_BITS-1:0] right_alpha_o,
  input logic [ANGLE_BITS-2:0] right_beta_o
);

  localparam logic [ANGLE_BITS-1:0] PI_A   = {1'b1, {(ANGLE_BITS-1){1'b0}}};
  localparam logic [ANGLE_BITS-2:0] HALF_B = {1'b1, {(ANGLE_BITS-2){1'b0}}};

  // A stalled result keeps its alpha angles and its left beta angle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(left_alpha_o) && $stable(right_alpha_o) && $stable(left_beta_o))
    else $error("stalled result changed");

  // An accepted item keeps the input side busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while solving");

  // A new result only comes out of an item in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without an item");

  // Angles stay in their ranges
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> left_alpha_o <= PI_A && right_alpha_o <= PI_A &&
      left_beta_o <= HALF_B && right_beta_o <= HALF_B)
    else $error("angle out of range");

endmodule

bind five_bar_leg_inverse_kinematics_core fbik_checker #(.ANGLE_BITS(ANGLE_BITS)) u_fbik_checker (
  .clk_i,
  .rst_ni,
  .in_valid_i,
  .in_stall_o,
  .out_valid_o,
  .out_stall_i,
  .left_alpha_o,
  .left_beta_o,
  .right_alpha_o,
  .right_beta_o
);
